### hdl/obp_pkg.sv
// Package for the online bin packing unit.
// Holds widths, capacity constants, policy codes and state codes shared by the design files.
// No dependencies.
package obp_pkg;

   localparam int MAX_BINS  = 256;
   localparam int FRAC_BITS = 16;
   localparam int SIZE_W    = FRAC_BITS + 1;
   localparam int SUM_W     = SIZE_W + 1;
   localparam int IDX_W     = $clog2(MAX_BINS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int OUT_IDX_W = 8;
   localparam int OUT_CNT_W = 9;
   localparam int POL_W     = 2;

   localparam logic [SUM_W-1:0] ONE_LEVEL = SUM_W'(1) << FRAC_BITS;
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BINS);

   typedef enum logic [POL_W-1:0] {
      POL_NEXT  = 2'd0,
      POL_FIRST = 2'd1,
      POL_BEST  = 2'd2,
      POL_WORST = 2'd3
   } obp_policy_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_NEXT  = 6'b000010,
      ST_FLUSH = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_PLACE = 6'b010000,
      ST_DONE  = 6'b100000
   } obp_state_type;

endpackage

### hdl/obp_ram.sv
// Generic single-port RAM with registered read data (valid in the cycle after the address).
// Width and depth are parameters; no dependencies.
module obp_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

### hdl/online_bin_packing_unit.sv
// Online bin packing unit: next, first, best and worst fit over a table of bin levels.
// Depends on obp_pkg and obp_ram (bin level table).
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_item_size, req_last_item
//   rsp      out        rsp_valid/rsp_ready  rsp_bin_index, rsp_opened_new,
//                                            rsp_bins_used, rsp_table_full
//   csr      in         csr_valid/csr_ready  csr_policy
//
// Next fit steps through idle, next and result states. Table policies step through idle,
// flush, scan, place and result states; the scan makes one RAM read per bin held after
// the flush and then drains. Reset clears control state only and holds
// both ready outputs low; only table entries below the bin count are checked. A stalled
// result stays in the output register while the next request runs; that one then waits
// in the result state and holds off further requests until the output register frees.
module online_bin_packing_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [obp_pkg::SIZE_W-1:0]     req_item_size,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [obp_pkg::OUT_IDX_W-1:0]  rsp_bin_index,
   output logic                           rsp_opened_new,
   output logic [obp_pkg::OUT_CNT_W-1:0]  rsp_bins_used,
   output logic                           rsp_table_full,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [obp_pkg::POL_W-1:0]      csr_policy
);

   import obp_pkg::*;

   obp_state_type        state_ff, state_in;
   obp_policy_type       policy_ff;
   logic [SIZE_W-1:0]    item_ff;
   logic                 last_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SIZE_W-1:0]    open_ff, open_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_W-1:0]    pick_sum_ff, pick_sum_in;
   logic [OUT_IDX_W-1:0] res_idx_ff, res_idx_in;
   logic                 res_open_ff, res_open_in;
   logic [OUT_CNT_W-1:0] res_used_ff, res_used_in;
   logic                 res_full_ff, res_full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic                 rsp_open_ff;
   logic [OUT_CNT_W-1:0] rsp_used_ff;
   logic                 rsp_full_ff;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_addr;
   logic [SIZE_W-1:0]    ram_wdata;
   logic [SIZE_W-1:0]    ram_rdata;

   logic [SUM_W-1:0]     chk_sum;
   logic                 chk_fit;
   logic                 chk_better;
   logic [SUM_W-1:0]     nf_sum;
   logic                 req_fire;
   logic                 rsp_load;

   obp_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_BINS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = !reset;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign chk_sum    = SUM_W'(ram_rdata) + SUM_W'(item_ff);
   assign chk_fit    = (chk_sum <= ONE_LEVEL);
   assign chk_better = !found_ff
                    || ((policy_ff == POL_BEST)  && (chk_sum > SUM_W'(pick_sum_ff)))
                    || ((policy_ff == POL_WORST) && (chk_sum < SUM_W'(pick_sum_ff)));
   assign nf_sum     = SUM_W'(open_ff) + SUM_W'(item_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      open_in      = open_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = scan_ff[IDX_W-1:0];
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_sum_in  = pick_sum_ff;
      res_idx_in   = res_idx_ff;
      res_open_in  = res_open_ff;
      res_used_in  = res_used_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_addr     = count_ff[IDX_W-1:0];
      ram_wdata    = open_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (policy_ff == POL_NEXT) ? ST_NEXT : ST_FLUSH;
            end
         end
         ST_NEXT: begin
            res_idx_in  = OUT_IDX_W'(count_ff);
            res_open_in = 1'b0;
            res_full_in = 1'b0;
            if (open_ff == '0) begin
               if (item_ff != '0) begin
                  if (count_ff < CNT_MAX) begin
                     open_in     = item_ff;
                     res_open_in = 1'b1;
                  end else begin
                     res_full_in = 1'b1;
                     res_idx_in  = '0;
                  end
               end
            end else if (nf_sum <= ONE_LEVEL) begin
               open_in = nf_sum[SIZE_W-1:0];
            end else if ((count_ff + CNT_W'(1)) < CNT_MAX) begin
               ram_we      = 1'b1;
               count_in    = count_ff + CNT_W'(1);
               open_in     = item_ff;
               res_idx_in  = OUT_IDX_W'(count_in);
               res_open_in = 1'b1;
            end else begin
               res_full_in = 1'b1;
               res_idx_in  = '0;
            end
            res_used_in = OUT_CNT_W'(count_in) + OUT_CNT_W'(open_in != '0);
            state_in    = ST_DONE;
         end
         ST_FLUSH: begin
            if ((open_ff != '0) && (count_ff < CNT_MAX)) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            open_in  = '0;
            scan_in  = '0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            ram_addr = scan_ff[IDX_W-1:0];
            if (scan_ff < count_ff) begin
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (chk_fit && chk_better) begin
                  found_in    = 1'b1;
                  pick_in     = chk_idx_ff;
                  pick_sum_in = chk_sum[SIZE_W-1:0];
               end
            end else if (scan_ff >= count_ff) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            res_full_in = 1'b0;
            res_open_in = 1'b0;
            if (found_ff) begin
               ram_we      = 1'b1;
               ram_addr    = pick_ff;
               ram_wdata   = pick_sum_ff;
               res_idx_in  = OUT_IDX_W'(pick_ff);
               res_used_in = OUT_CNT_W'(count_ff);
            end else if (count_ff < CNT_MAX) begin
               ram_we      = 1'b1;
               ram_wdata   = item_ff;
               count_in    = count_ff + CNT_W'(1);
               res_idx_in  = OUT_IDX_W'(count_ff);
               res_open_in = 1'b1;
               res_used_in = OUT_CNT_W'(count_in);
            end else begin
               res_idx_in  = '0;
               res_used_in = OUT_CNT_W'(count_ff);
               res_full_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (last_ff) begin
                  count_in = '0;
                  open_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FIRST;
         count_ff     <= '0;
         open_ff      <= '0;
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         scan_ff      <= scan_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= obp_policy_type'(csr_policy);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item_size;
         last_ff <= req_last_item;
      end
      chk_idx_ff  <= chk_idx_in;
      pick_ff     <= pick_in;
      pick_sum_ff <= pick_sum_in;
      res_idx_ff  <= res_idx_in;
      res_open_ff <= res_open_in;
      res_used_ff <= res_used_in;
      res_full_ff <= res_full_in;
      if (rsp_load) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_open_ff <= res_open_ff;
         rsp_used_ff <= res_used_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_index  = rsp_idx_ff;
   assign rsp_opened_new = rsp_open_ff;
   assign rsp_bins_used  = rsp_used_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

### tb/sv/online_bin_packing_unit_tb.sv
// Self-checking testbench for online_bin_packing_unit: directed table, then random runs.
// Predicts untyped placements from its own bin table; checks the rsp channel in order.
// Depends on obp_pkg and the online_bin_packing_unit RTL.
`timescale 1ns / 1ps

module online_bin_packing_unit_tb;
   import obp_pkg::*;

   localparam int unsigned UNIT        = 1 << FRAC_BITS;
   localparam int          HOLD_CYCLES = 700;
   localparam int          TAIL_CYCLES = 300;
   localparam int          NUM_VECTORS = 23;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] bin;
      logic                 opened;
      logic [OUT_CNT_W-1:0] used;
      logic                 full;
   } placement_type;

   typedef struct {
      bit             wr_pol;
      obp_policy_type pol;
      int unsigned    sz;
      bit             last;
      bit             typed;
      placement_type  want;
   } vector_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SIZE_W-1:0]    req_item_size = '0;
   logic                 req_last_item = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_IDX_W-1:0] rsp_bin_index;
   logic                 rsp_opened_new;
   logic [OUT_CNT_W-1:0] rsp_bins_used;
   logic                 rsp_table_full;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [POL_W-1:0]     csr_policy = POL_FIRST;

   int unsigned    level_tab[MAX_BINS];
   int unsigned    held_bins = 0;
   int unsigned    open_fill = 0;
   obp_policy_type cur_pol = POL_FIRST;
   placement_type  placements_due[$];
   int             errors = 0;
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             hold_asked = 0;
   int             hold_seen = 0;
   int             hold_left = 0;

   vector_type vectors[NUM_VECTORS] = '{
      '{0, POL_FIRST, 0,      0, 1, '{8'd0, 1'b1, 9'd1, 1'b0}},
      '{0, POL_FIRST, 65536,  0, 1, '{8'd0, 1'b0, 9'd1, 1'b0}},
      '{0, POL_FIRST, 1,      0, 1, '{8'd1, 1'b1, 9'd2, 1'b0}},
      '{0, POL_FIRST, 131071, 0, 1, '{8'd2, 1'b1, 9'd3, 1'b0}},
      '{0, POL_FIRST, 65535,  1, 1, '{8'd1, 1'b0, 9'd3, 1'b0}},
      '{1, POL_NEXT,  0,      0, 1, '{8'd0, 1'b0, 9'd0, 1'b0}},
      '{0, POL_NEXT,  40000,  0, 1, '{8'd0, 1'b1, 9'd1, 1'b0}},
      '{0, POL_NEXT,  30000,  0, 1, '{8'd1, 1'b1, 9'd2, 1'b0}},
      '{0, POL_NEXT,  131071, 0, 1, '{8'd2, 1'b1, 9'd3, 1'b0}},
      '{0, POL_NEXT,  20000,  1, 0, '0},
      '{0, POL_NEXT,  131071, 0, 1, '{8'd0, 1'b1, 9'd1, 1'b0}},
      '{0, POL_NEXT,  1,      1, 1, '{8'd1, 1'b1, 9'd2, 1'b0}},
      '{1, POL_BEST,  30000,  0, 0, '0},
      '{0, POL_BEST,  50000,  0, 0, '0},
      '{0, POL_BEST,  20000,  0, 0, '0},
      '{0, POL_BEST,  10000,  1, 0, '0},
      '{1, POL_WORST, 30000,  0, 0, '0},
      '{0, POL_WORST, 50000,  0, 0, '0},
      '{0, POL_WORST, 10000,  1, 0, '0},
      '{1, POL_NEXT,  40000,  0, 0, '0},
      '{1, POL_FIRST, 20000,  0, 0, '0},
      '{1, POL_NEXT,  0,      0, 0, '0},
      '{0, POL_NEXT,  30000,  1, 0, '0}
   };

   online_bin_packing_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item_size  (req_item_size),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_opened_new (rsp_opened_new),
      .rsp_bins_used  (rsp_bins_used),
      .rsp_table_full (rsp_table_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_policy     (csr_policy)
   );

   always #2 clock = ~clock;

   function automatic placement_type place_item(int unsigned sz, bit last);
      placement_type r;
      int unsigned   idx;
      int unsigned   pick;
      int unsigned   pick_room;
      int unsigned   room;
      int unsigned   i;
      bit            found;
      bit            opened;
      bit            full;
      idx = held_bins;
      opened = 1'b0;
      full = 1'b0;
      if (cur_pol == POL_NEXT) begin
         if (open_fill == 0) begin
            if (sz != 0) begin
               if (held_bins < MAX_BINS) begin
                  open_fill = sz;
                  opened = 1'b1;
               end else begin
                  full = 1'b1;
                  idx = 0;
               end
            end
         end else if (open_fill + sz <= UNIT) begin
            open_fill += sz;
         end else if (held_bins + 1 < MAX_BINS) begin
            level_tab[held_bins] = open_fill;
            held_bins++;
            open_fill = sz;
            idx = held_bins;
            opened = 1'b1;
         end else begin
            full = 1'b1;
            idx = 0;
         end
         r.used = OUT_CNT_W'(held_bins + (open_fill != 0 ? 1 : 0));
      end else begin
         // flush a nonempty next-fit bin into the table
         if (open_fill != 0 && held_bins < MAX_BINS) begin
            level_tab[held_bins] = open_fill;
            held_bins++;
         end
         open_fill = 0;
         found = 1'b0;
         pick = 0;
         pick_room = 0;
         for (i = 0; i < held_bins; i++) begin
            if (level_tab[i] + sz > UNIT) continue;
            room = UNIT - (level_tab[i] + sz);
            if (!found) begin
               found = 1'b1;
               pick = i;
               pick_room = room;
               if (cur_pol == POL_FIRST) break;
            end else if ((cur_pol == POL_BEST && room < pick_room) ||
                         (cur_pol == POL_WORST && room > pick_room)) begin
               pick = i;
               pick_room = room;
            end
         end
         if (found) begin
            level_tab[pick] += sz;
         end else if (held_bins < MAX_BINS) begin
            level_tab[held_bins] = sz;
            pick = held_bins;
            held_bins++;
            opened = 1'b1;
         end else begin
            pick = 0;
            full = 1'b1;
         end
         idx = pick;
         r.used = OUT_CNT_W'(held_bins);
      end
      r.bin = OUT_IDX_W'(idx);
      r.opened = opened;
      r.full = full;
      if (last) begin
         held_bins = 0;
         open_fill = 0;
      end
      return r;
   endfunction

   function automatic int unsigned pick_size();
      case ($urandom_range(15))
         0:       return 0;
         1:       return UNIT;
         2:       return $urandom_range(UNIT + 1, 2 * UNIT - 1);
         3:       return $urandom_range(1, 64);
         4, 5, 6: return $urandom_range(UNIT / 2 + 1, UNIT - 1);
         default: return $urandom_range(1, UNIT / 2);
      endcase
   endfunction

   task automatic send_item(int unsigned sz, bit last, bit typed, placement_type want);
      placement_type p;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item_size <= SIZE_W'(sz);
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
      p = place_item(sz, last);
      placements_due = {placements_due, (typed ? want : p)};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (placements_due.size() != 0);
   endtask

   task automatic set_policy(obp_policy_type p);
      csr_valid <= 1'b1;
      csr_policy <= p;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_pol = p;
   endtask

   task automatic run_mix(int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(2) == 0) begin
            drain();
            set_policy(obp_policy_type'($urandom_range(3)));
         end
         len = $urandom_range(1, 24);
         for (int k = 0; k < len; k++) begin
            // switch policy in the middle of a run
            if (k > 0 && $urandom_range(11) == 0) begin
               drain();
               set_policy(obp_policy_type'($urandom_range(3)));
            end
            send_item(pick_size(), k == len - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Every item above half a bin needs a bin of its own: fill the table, then overflow it.
   task automatic fill_bins(obp_policy_type p);
      drain();
      set_policy(p);
      for (int k = 0; k < MAX_BINS + 3; k++)
         send_item($urandom_range(UNIT / 2 + 1, UNIT), 1'b0, 1'b0, '0);
      if (p != POL_NEXT) begin
         drain();
         set_policy(POL_NEXT);
      end
      send_item(0, 1'b0, 1'b0, '0);
      send_item($urandom_range(1, UNIT), 1'b0, 1'b0, '0);
      send_item(pick_size(), 1'b1, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      placement_type got;
      placement_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_bin_index, rsp_opened_new, rsp_bins_used, rsp_table_full};
         if (placements_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected placement: bin %0d new %0d used %0d full %0d",
                     $time, got.bin, got.opened, got.used, got.full);
         end else begin
            w = placements_due.pop_front();
            if (got.bin !== w.bin || got.opened !== w.opened || got.used !== w.used ||
                got.full !== w.full) begin
               errors++;
               $display("%0t: placement mismatch: expected bin %0d new %0d used %0d full %0d",
                        $time, w.bin, w.opened, w.used, w.full);
               $display("%0t:                     actual   bin %0d new %0d used %0d full %0d",
                        $time, got.bin, got.opened, got.used, got.full);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[n]) begin
         if (vectors[n].wr_pol) begin
            drain();
            set_policy(vectors[n].pol);
         end
         send_item(vectors[n].sz, vectors[n].last, vectors[n].typed, vectors[n].want);
      end

      gap_pct = 0;
      stall_pct = 0;
      run_mix(150);
      fill_bins(POL_BEST);

      // hold off the receiver while requests keep coming, then wait for all results
      drain();
      hold_asked++;
      for (int k = 0; k < 12; k++)
         send_item(pick_size(), k == 11, 1'b0, '0);
      drain();

      gap_pct = 58;
      run_mix(150);

      gap_pct = 0;
      stall_pct = 58;
      run_mix(150);
      fill_bins(POL_NEXT);

      gap_pct = 25;
      stall_pct = 25;
      run_mix(140);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### online_bin_packing_unit.f
hdl/obp_pkg.sv
hdl/obp_ram.sv
hdl/online_bin_packing_unit.sv
tb/sv/online_bin_packing_unit_tb.sv
